[hdl/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the shell line tokenizer
// Character codes, result kinds, limits and the bundle that carries the
// results of one input byte from the front end to the back end.
// ----------------------------------------------------------------------------
package slt_pkg;

    // Character codes that steer the tokenizer.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // A word is cut once it holds this many bytes.
    localparam logic [5:0] WORD_LIMIT = 6'd63;
    // Hard ceiling on the number of words kept per line.
    localparam logic [4:0] MAX_WORDS  = 5'd16;
    localparam logic [4:0] MAX_TOKENS_RESET = 5'd16;

    // Result kinds, carried on tuser.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_EOW  = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;

    // Output tdata: data[7:0], word_index[11:8], word_count[16:12], zero pad.
    localparam int TDATA_W = 24;

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Everything one input byte produces: an optional word byte, an optional
    // end of word and an optional end of line, emitted in that order.
    typedef struct packed {
        logic       byte_vld;
        logic [7:0] byte_data;
        logic [3:0] byte_idx;
        logic       eow_vld;
        logic [3:0] eow_idx;
        logic       eol_vld;
        logic [4:0] eol_count;
    } t_bundle;

    // Front end to queue.
    typedef struct packed {
        logic    push;
        t_bundle bundle;
    } t_push;

endpackage

[hdl/shell_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// shell_line_tokenizer: command line word splitter
// Splits a command line into words with shell-like quoting and escapes.
//
// Input stream: one byte per transaction on i_s_axis_tdata, with
// i_s_axis_tlast on the final byte of the line. The front end takes one
// byte per cycle as long as the four-entry bundle queue has room.
// Output stream: one result per transaction. tuser holds the kind (word
// byte, end of word, end of line), tdata holds the byte, the word index and
// the word count, and tlast marks the last result caused by one input byte.
// A byte yields zero to three results, which are registered in the queue
// before they appear. The back end emits one result per cycle while the
// output is ready, so the sustained rate is one byte per cycle while bytes
// average at most one result, and one result per cycle otherwise. A stall on
// the output fills the queue and then drops o_s_axis_tready.
// Configuration: i_cfg_data sets the word limit per line (reset 16); it is
// always accepted and should be written only while the block is idle.
// Reset (synchronous, active low) empties the queue and clears the line state.
// ----------------------------------------------------------------------------
module shell_line_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // ch[7:0]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // data[7:0], word_index[11:8], word_count[16:12]
    output logic [1:0]  o_m_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    slt_pkg::t_push   push;
    slt_pkg::t_bundle head;
    logic             q_full;
    logic             q_valid;
    logic             pop;

    assign o_cfg_ready = 1'b1;

    slt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_ch         (i_s_axis_tdata),
        .i_line_last  (i_s_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (q_full),
        .o_push       (push)
    );

    slt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    slt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_kind       (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast)
    );

endmodule

[hdl/slt_front.sv]
// ----------------------------------------------------------------------------
// slt_front: byte classifier and tokenizer state
// Takes one byte per cycle while the queue has room, updates quote, escape
// and word state, and hands a bundle of up to three results to the queue.
// ----------------------------------------------------------------------------
module slt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_ch,
    input  logic                 i_line_last,
    input  logic                 i_cfg_valid,
    input  logic [4:0]           i_cfg_data,
    input  logic                 i_queue_full,
    output slt_pkg::t_push       o_push
);

    typedef enum logic [2:0] {
        PH_BETWEEN = 3'b001,
        PH_WORD    = 3'b010,
        PH_SKIP    = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_quote;

    typedef struct packed {
        t_phase     phase;
        t_quote     quote;
        logic       esc;
        logic [5:0] wlen;
        logic [4:0] wdone;
    } t_tok_state;

    typedef struct packed {
        t_tok_state st;
        logic       eow_vld;
        logic [3:0] eow_idx;
    } t_end_res;

    // Closes the current word; an empty word leaves no trace.
    function automatic t_end_res f_end_word(input t_tok_state st, input logic [4:0] cap);
        t_end_res r;
        r.st      = st;
        r.eow_vld = 1'b0;
        r.eow_idx = st.wdone[3:0];
        if (st.wlen != 6'd0) begin
            r.eow_vld  = 1'b1;
            r.st.wdone = st.wdone + 5'd1;
        end
        r.st.wlen  = 6'd0;
        r.st.quote = Q_NONE;
        r.st.esc   = 1'b0;
        r.st.phase = (r.st.wdone >= cap) ? PH_SKIP : PH_BETWEEN;
        return r;
    endfunction

    t_tok_state r_st;
    t_tok_state n_st;
    logic [4:0] r_max_tokens;
    logic [4:0] cap;
    logic       fire;

    t_tok_state       v;
    t_end_res         er;
    slt_pkg::t_bundle b;
    logic             do_word;
    logic             do_emit;
    logic             do_end;
    logic             do_hash;
    logic             is_sep;
    logic [7:0]       close_q;

    assign cap     = (r_max_tokens > slt_pkg::MAX_WORDS) ? slt_pkg::MAX_WORDS : r_max_tokens;
    assign o_ready = !i_queue_full;
    assign fire    = i_valid && o_ready;
    assign is_sep  = (i_ch == slt_pkg::CH_SPACE) || (i_ch == slt_pkg::CH_TAB);
    assign close_q = (r_st.quote == Q_SINGLE) ? slt_pkg::CH_SQUOTE : slt_pkg::CH_DQUOTE;

    always_comb begin
        v       = r_st;
        er      = '0;
        b       = '0;
        do_word = 1'b0;
        do_emit = 1'b0;
        do_end  = 1'b0;
        do_hash = 1'b0;

        case (r_st.phase)
            PH_BETWEEN: begin
                if (r_st.wdone >= cap) begin
                    v.phase = PH_SKIP;
                end else if (is_sep) begin
                    v.phase = PH_BETWEEN;
                end else if (i_ch == slt_pkg::CH_HASH) begin
                    v.phase = PH_SKIP;
                end else begin
                    v.phase = PH_WORD;
                    v.wlen  = 6'd0;
                    v.quote = Q_NONE;
                    v.esc   = 1'b0;
                    do_word = 1'b1;
                end
            end
            PH_WORD: begin
                do_word = 1'b1;
            end
            PH_SKIP: begin
                v.phase = PH_SKIP;
            end
            default: begin
                v.phase = PH_SKIP;
            end
        endcase

        // The in-word decision; quote and escape of a fresh word are clear,
        // which the checks on v below reflect.
        if (do_word) begin
            if (v.esc) begin
                v.esc   = 1'b0;
                do_emit = 1'b1;
            end else if (v.quote != Q_NONE) begin
                if (i_ch == close_q) begin
                    v.quote = Q_NONE;
                end else if (i_ch == slt_pkg::CH_BSLASH && !i_line_last) begin
                    v.esc = 1'b1;
                end else begin
                    do_emit = 1'b1;
                end
            end else if (i_ch == slt_pkg::CH_SQUOTE) begin
                v.quote = Q_SINGLE;
            end else if (i_ch == slt_pkg::CH_DQUOTE) begin
                v.quote = Q_DOUBLE;
            end else if (i_ch == slt_pkg::CH_BSLASH && !i_line_last) begin
                v.esc = 1'b1;
            end else if (is_sep) begin
                do_end = 1'b1;
            end else if (i_ch == slt_pkg::CH_HASH) begin
                do_end  = 1'b1;
                do_hash = 1'b1;
            end else begin
                do_emit = 1'b1;
            end
        end

        if (do_emit) begin
            b.byte_vld  = 1'b1;
            b.byte_data = i_ch;
            b.byte_idx  = v.wdone[3:0];
            v.wlen      = v.wlen + 6'd1;
            if (v.wlen >= slt_pkg::WORD_LIMIT) begin
                do_end = 1'b1;
            end
        end

        if (do_end) begin
            er        = f_end_word(v, cap);
            v         = er.st;
            b.eow_vld = er.eow_vld;
            b.eow_idx = er.eow_idx;
        end

        if (do_hash) begin
            v.phase = PH_SKIP;
        end

        if (i_line_last) begin
            // Only one word end can happen per byte: a word closed above
            // already left the word phase.
            if (v.phase == PH_WORD) begin
                er        = f_end_word(v, cap);
                v         = er.st;
                b.eow_vld = er.eow_vld;
                b.eow_idx = er.eow_idx;
            end
            b.eol_vld   = 1'b1;
            b.eol_count = v.wdone;
            v.phase     = PH_BETWEEN;
            v.quote     = Q_NONE;
            v.esc       = 1'b0;
            v.wlen      = 6'd0;
            v.wdone     = 5'd0;
        end

        n_st = fire ? v : r_st;
    end

    assign o_push.push   = fire && (b.byte_vld || b.eow_vld || b.eol_vld);
    assign o_push.bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase   <= PH_BETWEEN;
            r_st.quote   <= Q_NONE;
            r_st.esc     <= 1'b0;
            r_st.wlen    <= 6'd0;
            r_st.wdone   <= 5'd0;
            r_max_tokens <= slt_pkg::MAX_TOKENS_RESET;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) begin
                r_max_tokens <= i_cfg_data;
            end
        end
    end

endmodule

[hdl/slt_queue.sv]
// ----------------------------------------------------------------------------
// slt_queue: short bundle queue
// Decouples the classifier from the result serializer so that either side
// can stall without holding up the other until the queue fills or empties.
// ----------------------------------------------------------------------------
module slt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slt_pkg::t_push    i_push,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output slt_pkg::t_bundle  o_head
);

    slt_pkg::t_bundle                r_mem [slt_pkg::QUEUE_DEPTH];
    logic [slt_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [slt_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [slt_pkg::QPTR_W:0]        r_count;
    logic [slt_pkg::QPTR_W:0]        n_count;
    logic                            do_pop;

    assign o_full  = (r_count == (slt_pkg::QPTR_W+1)'(slt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push.push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

[hdl/slt_back.sv]
// ----------------------------------------------------------------------------
// slt_back: result serializer
// Walks through the results of the bundle at the queue head, one per
// transaction, and releases the bundle after its last result.
// ----------------------------------------------------------------------------
module slt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  slt_pkg::t_bundle              i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [slt_pkg::TDATA_W-1:0]   o_data,
    output logic [1:0]                    o_kind,
    output logic                          o_last
);

    // One bit per result of the bundle: byte, end of word, end of line.
    logic [2:0] r_sent;
    logic [2:0] n_sent;
    logic [2:0] rem;
    logic [2:0] sel;
    logic [7:0] f_data;
    logic [3:0] f_idx;
    logic [4:0] f_cnt;
    logic       fire;

    assign rem     = {i_head.eol_vld, i_head.eow_vld, i_head.byte_vld} & ~r_sent;
    assign sel     = rem & (~rem + 3'd1);
    assign o_last  = ((rem & ~sel) == 3'd0);
    assign o_valid = i_head_valid;
    assign fire    = o_valid && i_ready;
    assign o_pop   = fire && o_last;

    always_comb begin
        f_data = 8'd0;
        f_idx  = 4'd0;
        f_cnt  = 5'd0;
        o_kind = slt_pkg::KIND_BYTE;
        case (sel)
            3'b001: begin
                o_kind = slt_pkg::KIND_BYTE;
                f_data = i_head.byte_data;
                f_idx  = i_head.byte_idx;
            end
            3'b010: begin
                o_kind = slt_pkg::KIND_EOW;
                f_idx  = i_head.eow_idx;
            end
            3'b100: begin
                o_kind = slt_pkg::KIND_EOL;
                f_cnt  = i_head.eol_count;
            end
            default: begin
                o_kind = slt_pkg::KIND_BYTE;
            end
        endcase
    end

    assign o_data = {{(slt_pkg::TDATA_W - 17){1'b0}}, f_cnt, f_idx, f_data};

    always_comb begin
        n_sent = r_sent;
        if (fire) begin
            n_sent = o_last ? 3'd0 : (r_sent | sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent <= 3'd0;
        end else begin
            r_sent <= n_sent;
        end
    end

endmodule

[hdl/slt_checker.sv]
// ----------------------------------------------------------------------------
// slt_checker: port-level checks of the shell line tokenizer
// Watches the output for held results, consistent fields and none after reset.
// ----------------------------------------------------------------------------
module slt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [4:0]  i_cfg_data
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output result changed while stalled");

    // The end of line is always the final result of its byte.
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == slt_pkg::KIND_EOL |-> o_m_axis_tlast)
        else $error("end of line not marked as last result");

    // Only word bytes carry data, and only line ends carry a count.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == slt_pkg::KIND_BYTE || o_m_axis_tdata[7:0] == 8'd0)
            && (o_m_axis_tuser == slt_pkg::KIND_EOL || o_m_axis_tdata[16:12] == 5'd0))
        else $error("result field set for the wrong kind");

    // Reset leaves nothing to deliver.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered right after reset");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (.*);

[sim/slt_token_checker.sv]
// ----------------------------------------------------------------------------
// slt_token_checker: result predictor and comparator for the line tokenizer
// Watches the input, output and configuration channels of the tokenizer,
// predicts the results of every accepted input byte and compares each output
// transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module slt_token_checker
    import slt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic [1:0]  i_out_kind,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    output int          o_mismatches,
    output int          o_pending
);

    typedef enum logic [1:0] {SCAN_GAP, SCAN_WORD, SCAN_SKIP} t_scan;
    typedef enum logic [1:0] {QUOTE_NONE, QUOTE_SINGLE, QUOTE_DOUBLE} t_quote;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] word_idx;
        logic [4:0] count;
        logic       last;
    } t_token;

    t_scan      scan = SCAN_GAP;
    t_quote     quote = QUOTE_NONE;
    logic       escaped = 1'b0;
    int         word_len = 0;
    int         words_done = 0;
    logic [4:0] word_limit_reg = MAX_TOKENS_RESET;

    t_token     step_tokens[3];
    int         step_n = 0;
    t_token     expected_tokens[$];
    int         mismatch_cnt = 0;

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        $display("[%0t] tokenizer mismatch: %s", $time, msg);
    endtask

    function automatic int word_cap();
        return (word_limit_reg > MAX_WORDS) ? int'(MAX_WORDS) : int'(word_limit_reg);
    endfunction

    task automatic add_token(input logic [1:0] kind, input logic [7:0] data,
                             input logic [3:0] idx, input logic [4:0] count);
        step_tokens[step_n] = '{kind, data, idx, count, 1'b0};
        step_n++;
    endtask

    task automatic clear_line();
        scan       = SCAN_GAP;
        quote      = QUOTE_NONE;
        escaped    = 1'b0;
        word_len   = 0;
        words_done = 0;
    endtask

    // Empty words produce nothing and are not counted.
    task automatic close_word();
        if (word_len > 0) begin
            add_token(KIND_EOW, 8'd0, words_done[3:0], 5'd0);
            words_done++;
        end
        word_len = 0;
        quote    = QUOTE_NONE;
        escaped  = 1'b0;
        scan     = (words_done >= word_cap()) ? SCAN_SKIP : SCAN_GAP;
    endtask

    task automatic take_char(input logic [7:0] c);
        add_token(KIND_BYTE, c, words_done[3:0], 5'd0);
        word_len++;
        if (word_len >= int'(WORD_LIMIT)) close_word();
    endtask

    // A backslash on the final byte of a line is an ordinary word byte.
    task automatic word_char(input logic [7:0] c, input logic last);
        if (escaped) begin
            escaped = 1'b0;
            take_char(c);
        end else if (quote != QUOTE_NONE) begin
            if ((quote == QUOTE_SINGLE && c == CH_SQUOTE) ||
                (quote == QUOTE_DOUBLE && c == CH_DQUOTE))
                quote = QUOTE_NONE;
            else if (c == CH_BSLASH && !last)
                escaped = 1'b1;
            else
                take_char(c);
        end else if (c == CH_SQUOTE) begin
            quote = QUOTE_SINGLE;
        end else if (c == CH_DQUOTE) begin
            quote = QUOTE_DOUBLE;
        end else if (c == CH_BSLASH && !last) begin
            escaped = 1'b1;
        end else if (c == CH_SPACE || c == CH_TAB) begin
            close_word();
        end else if (c == CH_HASH) begin
            close_word();
            scan = SCAN_SKIP;
        end else begin
            take_char(c);
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] c, input logic last);
        t_token tok;
        step_n = 0;
        case (scan)
            SCAN_GAP: begin
                if (words_done >= word_cap()) begin
                    scan = SCAN_SKIP;
                end else if (c == CH_HASH) begin
                    scan = SCAN_SKIP;
                end else if (c != CH_SPACE && c != CH_TAB) begin
                    scan     = SCAN_WORD;
                    word_len = 0;
                    quote    = QUOTE_NONE;
                    escaped  = 1'b0;
                    word_char(c, last);
                end
            end
            SCAN_WORD: begin
                word_char(c, last);
            end
            default: begin
            end
        endcase
        if (last) begin
            if (scan == SCAN_WORD) close_word();
            add_token(KIND_EOL, 8'd0, 4'd0, words_done[4:0]);
            clear_line();
        end
        for (int i = 0; i < step_n; i++) begin
            tok      = step_tokens[i];
            tok.last = (i == step_n - 1);
            expected_tokens.push_back(tok);
        end
    endtask

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            expected_tokens.delete();
            clear_line();
            word_limit_reg = MAX_TOKENS_RESET;
        end else begin
            // Outputs first: a result never belongs to a byte taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_kind, i_out_data[7:0], i_out_data[11:8], i_out_data[16:12],
                        i_out_last};
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d data %02h with none pending",
                                              got.kind, got.data));
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want || i_out_data[23:17] !== 7'd0)
                        report_mismatch($sformatf(
                            "got kind %0d data %02h word %0d count %0d last %0d pad %02h, %s",
                            got.kind, got.data, got.word_idx, got.count, got.last,
                            i_out_data[23:17],
                            $sformatf("want kind %0d data %02h word %0d count %0d last %0d",
                                      want.kind, want.data, want.word_idx, want.count,
                                      want.last)));
                end
            end
            if (i_cfg_valid && i_cfg_ready) word_limit_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) tokenize_byte(i_in_char, i_in_last);
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_tokens.size();
    end

endmodule

[sim/tb_shell_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// tb_shell_line_tokenizer: testbench of the shell line tokenizer
// Sends directed command lines and then random, mostly well-formed lines
// under several word limits, with random gaps on the input and random stalls
// on the output. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_shell_line_tokenizer;
    import slt_pkg::*;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_char = 8'd0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [23:0] out_data;
    logic [1:0]  out_kind;
    logic        out_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = 5'd0;

    int          mismatches;
    int          pending;
    logic        idle_on = 1'b1;
    logic        rx_calm = 1'b0;
    int          stall_left = 0;
    logic [7:0]  line_buf[$];

    shell_line_tokenizer u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_char),
        .i_s_axis_tlast  (in_last),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_kind),
        .o_m_axis_tlast  (out_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    slt_token_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_char    (in_char),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_out_kind   (out_kind),
        .i_out_last   (out_last),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("** shell_line_tokenizer: FAILED **");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 5) == 0) stall_left <= idle_length();
        end
    end

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    function automatic logic [7:0] rand_special();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_HASH;
            3: return CH_SQUOTE;
            4: return CH_DQUOTE;
            5: return CH_BSLASH;
            6: return 8'($urandom_range(128, 255));
            default: return rand_letter();
        endcase
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
    endtask

    task automatic add_sep();
        repeat ($urandom_range(1, 2)) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic add_quoted(input logic [7:0] q);
        line_buf.push_back(q);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
                0: begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(rand_special());
                end
                1: line_buf.push_back(rand_special());
                default: line_buf.push_back(rand_letter());
            endcase
        end
        line_buf.push_back(q);
    endtask

    task automatic add_word();
        logic [7:0] q;
        repeat ($urandom_range(1, 3)) begin
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            case ($urandom_range(0, 5))
                0: repeat ($urandom_range(1, 4)) line_buf.push_back(rand_letter());
                1: add_quoted(CH_SQUOTE);
                2: add_quoted(CH_DQUOTE);
                3: begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(rand_special());
                end
                4: begin
                    line_buf.push_back(q);
                    line_buf.push_back(q);
                end
                default: line_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
            endcase
        end
    endtask

    task automatic make_line();
        int shape;
        int n_words;
        line_buf.delete();
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(1, 255)));
        end else if (shape == 1) begin
            // More words than any word limit allows.
            repeat ($urandom_range(17, 19)) begin
                line_buf.push_back(rand_letter());
                line_buf.push_back(CH_SPACE);
            end
        end else begin
            if ($urandom_range(0, 3) == 0) add_sep();
            n_words = $urandom_range(0, 5);
            for (int w = 0; w < n_words; w++) begin
                if (w > 0) add_sep();
                add_word();
            end
            case ($urandom_range(0, 7))
                0: begin
                    line_buf.push_back(CH_HASH);
                    repeat ($urandom_range(0, 3)) line_buf.push_back(rand_special());
                end
                1: begin
                    line_buf.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
                    repeat ($urandom_range(0, 3)) line_buf.push_back(rand_letter());
                end
                2: line_buf.push_back(CH_BSLASH);
                3: add_sep();
                default: begin
                end
            endcase
            if (line_buf.size() == 0) line_buf.push_back(rand_letter());
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic last);
        in_valid <= 1'b1;
        in_char  <= c;
        in_last  <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stops sending and lets every pending result drain, plus the pipeline depth.
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        repeat (3) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic send_line(input logic allow_pause);
        int gap;
        idle_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < line_buf.size(); i++) begin
            if (allow_pause && i > 0 && $urandom_range(0, 59) == 0) wait_for_quiet();
            gap = idle_on ? idle_length() : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    task automatic write_word_limit(input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [4:0] limit_plan[6];
        int         phase_items;
        limit_plan = '{5'd1, 5'd16, 5'd4, 5'd0, 5'd2, MAX_WORDS};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines under the reset word limit.
        line_buf = '{8'h01, 8'h00, 8'hFF};
        send_line(1'b0);
        line_buf.delete();
        add_text("'' \"x\" #");
        send_line(1'b0);
        line_buf.delete();
        add_text("a\\ b\\");
        send_line(1'b0);
        line_buf.delete();
        add_text("\t'q");
        send_line(1'b0);
        line_buf.delete();
        add_text("\"\\\"\"");
        send_line(1'b0);
        line_buf.delete();
        add_text("'\\''");
        send_line(1'b0);
        line_buf.delete();
        add_text(" ");
        send_line(1'b0);

        for (int p = 0; p < 6; p++) begin
            wait_for_quiet();
            write_word_limit(limit_plan[p] == 5'd0 ? 5'($urandom_range(1, 16)) : limit_plan[p]);
            rx_calm     = (p == 2);
            phase_items = 0;
            if (p == 1 || p == 4) begin
                // A word around the cut length, mostly long enough to be cut, sometimes inside a quote.
                line_buf.delete();
                if ($urandom_range(0, 1)) line_buf.push_back(CH_DQUOTE);
                repeat ($urandom_range(61, 66)) line_buf.push_back(rand_letter());
                add_quoted(CH_SQUOTE);
                line_buf.push_back(CH_HASH);
                line_buf.push_back(rand_letter());
                phase_items += line_buf.size();
                send_line(1'b1);
            end
            while (phase_items < 30) begin
                make_line();
                phase_items += line_buf.size();
                send_line(1'b1);
            end
        end

        wait_for_quiet();
        if (mismatches == 0 && pending == 0)
            $display("** shell_line_tokenizer: PASSED **");
        else
            $display("** shell_line_tokenizer: FAILED **");
        $finish;
    end

endmodule

[files.f]
hdl/slt_pkg.sv
hdl/slt_front.sv
hdl/slt_queue.sv
hdl/slt_back.sv
hdl/shell_line_tokenizer.sv
hdl/slt_checker.sv
sim/slt_token_checker.sv
sim/tb_shell_line_tokenizer.sv
